### src/cln_pkg.sv
// shared types, constants and the event program for the lcd nibble sequencer
package cln_pkg;

    // field widths
    localparam int unsigned ActionW   = 3;
    localparam int unsigned ValueW    = 8;
    localparam int unsigned ColumnW   = 6;
    localparam int unsigned NibbleW   = 4;
    localparam int unsigned WaitW     = 17;
    localparam int unsigned StepW     = 4;
    localparam int unsigned CfgIndexW = 2;
    localparam int unsigned CfgDataW  = 17;

    // configuration register widths and reset values
    localparam int unsigned ShortW = 10;
    localparam int unsigned LongW  = 16;
    localparam int unsigned PowerW = 17;
    localparam logic [ShortW-1:0] ShortReset = ShortW'(100);
    localparam logic [LongW-1:0]  LongReset  = LongW'(5000);
    localparam logic [PowerW-1:0] PowerReset = PowerW'(50000);

    // configuration register indexes
    localparam logic [CfgIndexW-1:0] CFG_SHORT_WAIT   = 2'd0;
    localparam logic [CfgIndexW-1:0] CFG_LONG_WAIT    = 2'd1;
    localparam logic [CfgIndexW-1:0] CFG_POWERUP_WAIT = 2'd2;

    // command codes
    localparam logic [ActionW-1:0] ACT_WRITE_INSTR = 3'd0;
    localparam logic [ActionW-1:0] ACT_WRITE_DATA  = 3'd1;
    localparam logic [ActionW-1:0] ACT_CLEAR       = 3'd2;
    localparam logic [ActionW-1:0] ACT_SET_POS     = 3'd3;
    localparam logic [ActionW-1:0] ACT_INIT        = 3'd4;

    // lcd instruction bytes
    localparam logic [ValueW-1:0] LCD_SET_DDRAM = 8'h80;
    localparam logic [ValueW-1:0] LCD_FUNC_SET  = 8'h28;
    localparam logic [ValueW-1:0] LCD_DISP_ON   = 8'h0C;
    localparam logic [ValueW-1:0] LCD_ENTRY     = 8'h06;
    localparam logic [ValueW-1:0] LCD_DISP_CLR  = 8'h01;
    localparam logic [NibbleW-1:0] NIB_WAKE     = 4'h3;
    localparam logic [NibbleW-1:0] NIB_4BIT     = 4'h2;

    // kind of run being played out
    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_INIT  = 2'd2
    } kind_t;

    // where an event takes its nibble from
    typedef enum logic [1:0] {
        NSEL_HIGH  = 2'd0,
        NSEL_LOW   = 2'd1,
        NSEL_CONST = 2'd2
    } nib_sel_t;

    // which wait register follows an event
    typedef enum logic [1:0] {
        WSEL_SHORT = 2'd0,
        WSEL_LONG  = 2'd1,
        WSEL_POWER = 2'd2
    } wait_sel_t;

    // one entry of the event program
    typedef struct packed {
        logic                strobe;
        logic                rs_from_cmd;
        nib_sel_t            nib_sel;
        logic [NibbleW-1:0]  nib;
        wait_sel_t           wait_sel;
        logic                last;
    } tmpl_t;

    // controller to datapath
    typedef struct packed {
        logic             capture;
        logic             load;
        kind_t            kind;
        logic [StepW-1:0] step;
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic ev_last;
    } stat_t;

    function automatic tmpl_t strobe_ev(input logic [NibbleW-1:0] nib,
                                        input wait_sel_t ws, input logic last);
        tmpl_t t;
        t.strobe      = 1'b1;
        t.rs_from_cmd = 1'b0;
        t.nib_sel     = NSEL_CONST;
        t.nib         = nib;
        t.wait_sel    = ws;
        t.last        = last;
        return t;
    endfunction

    function automatic tmpl_t wait_ev(input wait_sel_t ws, input logic last);
        tmpl_t t;
        t.strobe      = 1'b0;
        t.rs_from_cmd = 1'b0;
        t.nib_sel     = NSEL_CONST;
        t.nib         = '0;
        t.wait_sel    = ws;
        t.last        = last;
        return t;
    endfunction

    // event program: template for step of a run
    function automatic tmpl_t event_tmpl(input kind_t kind, input logic [StepW-1:0] step);
        tmpl_t t;
        t = wait_ev(WSEL_LONG, 1'b1);
        unique case (kind)
            KIND_BYTE:
            begin
                t             = strobe_ev('0, WSEL_SHORT, step[0]);
                t.rs_from_cmd = 1'b1;
                t.nib_sel     = step[0] ? NSEL_LOW : NSEL_HIGH;
            end
            KIND_CLEAR:
            begin
                unique case (step)
                    4'd0:    t = strobe_ev(LCD_DISP_CLR[7:4], WSEL_SHORT, 1'b0);
                    4'd1:    t = strobe_ev(LCD_DISP_CLR[3:0], WSEL_SHORT, 1'b0);
                    default: t = wait_ev(WSEL_LONG, 1'b1);
                endcase
            end
            KIND_INIT:
            begin
                unique case (step)
                    4'd0:    t = wait_ev(WSEL_POWER, 1'b0);
                    4'd1:    t = strobe_ev(NIB_WAKE, WSEL_LONG, 1'b0);
                    4'd2:    t = strobe_ev(NIB_WAKE, WSEL_LONG, 1'b0);
                    4'd3:    t = strobe_ev(NIB_WAKE, WSEL_LONG, 1'b0);
                    4'd4:    t = strobe_ev(NIB_4BIT, WSEL_SHORT, 1'b0);
                    4'd5:    t = strobe_ev(LCD_FUNC_SET[7:4], WSEL_SHORT, 1'b0);
                    4'd6:    t = strobe_ev(LCD_FUNC_SET[3:0], WSEL_SHORT, 1'b0);
                    4'd7:    t = strobe_ev(LCD_DISP_ON[7:4], WSEL_SHORT, 1'b0);
                    4'd8:    t = strobe_ev(LCD_DISP_ON[3:0], WSEL_SHORT, 1'b0);
                    4'd9:    t = strobe_ev(LCD_ENTRY[7:4], WSEL_SHORT, 1'b0);
                    4'd10:   t = strobe_ev(LCD_ENTRY[3:0], WSEL_SHORT, 1'b0);
                    4'd11:   t = strobe_ev(LCD_DISP_CLR[7:4], WSEL_SHORT, 1'b0);
                    4'd12:   t = strobe_ev(LCD_DISP_CLR[3:0], WSEL_SHORT, 1'b0);
                    default: t = wait_ev(WSEL_LONG, 1'b1);
                endcase
            end
            default: t = wait_ev(WSEL_LONG, 1'b1);
        endcase
        return t;
    endfunction

endpackage

### src/cln_if.sv
// command and event channel interfaces
interface cln_cmd_if;
    import cln_pkg::*;
    logic               valid;
    logic               ready;
    logic [ActionW-1:0] action;
    logic [ValueW-1:0]  value;
    logic [ColumnW-1:0] column;
    logic               row;

    modport source (output valid, action, value, column, row, input ready);
    modport sink   (input valid, action, value, column, row, output ready);
endinterface

interface cln_evt_if;
    import cln_pkg::*;
    logic               valid;
    logic               ready;
    logic               strobe_res;
    logic               register_select;
    logic [NibbleW-1:0] nibble;
    logic [WaitW-1:0]   wait_us;
    logic               last;

    modport source (output valid, strobe_res, register_select, nibble, wait_us, last,
                    input ready);
    modport sink   (input valid, strobe_res, register_select, nibble, wait_us, last,
                    output ready);
endinterface

### src/char_lcd_nibble_sequencer.sv
// top level of the 4-bit character lcd bus sequencer
//
// cmd carries one command (action, value, column, row); evt carries the bus
// events it expands to: strobe_res (enable pulse or pure wait), register_select,
// nibble for D7..D4, wait_us after the event, and last on the final event.
// Writes of instruction, data and set position give two events, clear three
// and init fourteen; an unknown action is taken and gives none.
// A command is taken only while no run is in progress. The first event is
// registered once the controller has entered its run state, then one event
// per cycle follows while the receiver takes them; the step counter of the
// controller walks the event program.
// The event register is refilled in the cycle it is taken, so a stalled
// receiver just holds the current event and pauses the run.
// Wait registers short_wait_us, long_wait_us, powerup_wait_us are written
// through cfg_we/cfg_index/cfg_data at indexes 0, 1, 2, by the user only while
// idle; the block does not enforce it. Reset returns the block to idle with no
// event pending and restores the wait registers to 100, 5000 and 50000 us.
module char_lcd_nibble_sequencer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cln_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [cln_pkg::CfgDataW-1:0]  cfg_data,
    cln_cmd_if.sink                       cmd,
    cln_evt_if.source                     evt
);
    import cln_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    // sequencing control
    cln_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .action    (cmd.action),
        .out_valid (evt.valid),
        .out_ready (evt.ready),
        .ctrl      (ctrl),
        .stat      (stat)
    );

    // payload and wait registers
    cln_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .action          (cmd.action),
        .value           (cmd.value),
        .column          (cmd.column),
        .row             (cmd.row),
        .ctrl            (ctrl),
        .stat            (stat),
        .strobe_res      (evt.strobe_res),
        .register_select (evt.register_select),
        .nibble          (evt.nibble),
        .wait_us         (evt.wait_us),
        .last            (evt.last)
    );

endmodule

### src/cln_ctrl.sv
// controller: accepts commands and steps through the event program
module cln_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [cln_pkg::ActionW-1:0] action,
    output logic                    out_valid,
    input  logic                    out_ready,
    output cln_pkg::ctrl_t          ctrl,
    input  cln_pkg::stat_t          stat
);
    import cln_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    kind_t            kind_reg, kind_next;
    logic [StepW-1:0] step_reg, step_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;
    logic             load;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    // output register is free or emptied this cycle
    assign load      = (state_reg == ST_RUN) && (!out_valid_reg || out_ready);

    assign ctrl.capture = accept;
    assign ctrl.load    = load;
    assign ctrl.kind    = kind_reg;
    assign ctrl.step    = step_reg;

    // next state
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    step_next = '0;
                    unique case (action)
                        ACT_WRITE_INSTR, ACT_WRITE_DATA, ACT_SET_POS:
                        begin
                            kind_next  = KIND_BYTE;
                            state_next = ST_RUN;
                        end
                        ACT_CLEAR:
                        begin
                            kind_next  = KIND_CLEAR;
                            state_next = ST_RUN;
                        end
                        ACT_INIT:
                        begin
                            kind_next  = KIND_INIT;
                            state_next = ST_RUN;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RUN:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    step_next      = step_reg + 1'b1;
                    if (stat.ev_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= KIND_BYTE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### src/cln_dp.sv
// datapath: command byte, wait registers and the event output register
module cln_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cln_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [cln_pkg::CfgDataW-1:0]  cfg_data,
    input  logic [cln_pkg::ActionW-1:0]   action,
    input  logic [cln_pkg::ValueW-1:0]    value,
    input  logic [cln_pkg::ColumnW-1:0]   column,
    input  logic                          row,
    input  cln_pkg::ctrl_t                ctrl,
    output cln_pkg::stat_t                stat,
    output logic                          strobe_res,
    output logic                          register_select,
    output logic [cln_pkg::NibbleW-1:0]   nibble,
    output logic [cln_pkg::WaitW-1:0]     wait_us,
    output logic                          last
);
    import cln_pkg::*;

    logic [ShortW-1:0]  short_reg;
    logic [LongW-1:0]   long_reg;
    logic [PowerW-1:0]  power_reg;
    logic [ValueW-1:0]  byte_reg, byte_next;
    logic               rs_reg, rs_next;
    logic               strobe_reg;
    logic               sel_reg;
    logic [NibbleW-1:0] nib_reg, nib_next;
    logic [WaitW-1:0]   wait_reg, wait_next;
    logic               last_reg;
    tmpl_t              tmpl;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_reg <= ShortReset;
            long_reg  <= LongReset;
            power_reg <= PowerReset;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_SHORT_WAIT)
            begin
                short_reg <= cfg_data[ShortW-1:0];
            end
            if (cfg_index == CFG_LONG_WAIT)
            begin
                long_reg <= cfg_data[LongW-1:0];
            end
            if (cfg_index == CFG_POWERUP_WAIT)
            begin
                power_reg <= cfg_data[PowerW-1:0];
            end
        end
    end

    // byte to send: set position forms the ddram address
    always_comb
    begin
        byte_next = value;
        if (action == ACT_SET_POS)
        begin
            byte_next = LCD_SET_DDRAM | {1'b0, row, column};
        end
        rs_next = (action == ACT_WRITE_DATA);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            byte_reg <= byte_next;
            rs_reg   <= rs_next;
        end
    end

    // current event from the program
    always_comb
    begin
        tmpl = event_tmpl(ctrl.kind, ctrl.step);
        unique case (tmpl.nib_sel)
            NSEL_HIGH: nib_next = byte_reg[7:4];
            NSEL_LOW:  nib_next = byte_reg[3:0];
            default:   nib_next = tmpl.nib;
        endcase
        unique case (tmpl.wait_sel)
            WSEL_SHORT: wait_next = WaitW'(short_reg);
            WSEL_LONG:  wait_next = WaitW'(long_reg);
            default:    wait_next = WaitW'(power_reg);
        endcase
    end

    assign stat.ev_last = tmpl.last;

    // event output register
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            strobe_reg <= tmpl.strobe;
            sel_reg    <= tmpl.rs_from_cmd & rs_reg;
            nib_reg    <= nib_next;
            wait_reg   <= wait_next;
            last_reg   <= tmpl.last;
        end
    end

    assign strobe_res      = strobe_reg;
    assign register_select = sel_reg;
    assign nibble          = nib_reg;
    assign wait_us         = wait_reg;
    assign last            = last_reg;

endmodule
